// ===== rtl/core/blp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blp_pkg
// Shared widths, reset values, register indexes and fixed-point constants for
// the bandwidth latency penalty block.
// ----------------------------------------------------------------------------
package blp_pkg;

  localparam int unsigned LINE_BYTES_DEF = 64;

  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned FRAC_W     = 17;
  localparam int unsigned LAT_W      = 24;
  localparam int unsigned PEN_W      = 32;
  localparam int unsigned PEAK_W     = 16;
  localparam int unsigned LEVEL_W    = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned UTIL_W     = 24;
  localparam int unsigned TERM2_W    = 40;
  localparam int unsigned TERM3_W    = 42;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PEAK    = 3'd0,
    CFG_KNEE    = 3'd1,
    CFG_SAT     = 3'd2,
    CFG_SLOPE   = 3'd3,
    CFG_MAX_PEN = 3'd4,
    CFG_MIN_WIN = 3'd5
  } cfg_idx_t;

  localparam logic [PEAK_W-1:0]  PEAK_RST    = 16'd8192;
  localparam logic [LEVEL_W-1:0] KNEE_RST    = 17'd52429;
  localparam logic [LEVEL_W-1:0] SAT_RST     = 17'd64225;
  localparam logic [LEVEL_W-1:0] SLOPE_RST   = 17'd3277;
  localparam logic [PEN_W-1:0]   MAX_PEN_RST = 32'd1280000;
  localparam logic [31:0]        MIN_WIN_RST = 32'd100000;

  // 0.001 and 1.0 in Q1.16.
  localparam logic [LEVEL_W-1:0] EPS_Q16 = 17'd66;
  localparam logic [LEVEL_W-1:0] Q16_ONE = 17'h10000;

  localparam logic [UTIL_W-1:0]  UTIL_MAX  = 24'hFFFFFF;
  localparam logic [TERM2_W-1:0] TERM2_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [TERM3_W-1:0] TERM3_MAX = 42'h3FF_FFFF_FFFF;

endpackage

// ===== rtl/core/blp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blp_if
// Valid/ready channels of the bandwidth latency penalty block: window items
// in, penalty items out, and the register write port.
// ----------------------------------------------------------------------------
interface blp_in_if import blp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COUNT_W-1:0]  num_accesses;
  logic [TIME_W-1:0]   first_time;
  logic [TIME_W-1:0]   last_time;
  logic [FRAC_W-1:0]   read_fraction;
  logic [LAT_W-1:0]    read_latency;
  logic [LAT_W-1:0]    write_latency;

  modport source (
    output valid, num_accesses, first_time, last_time, read_fraction,
           read_latency, write_latency,
    input  ready
  );
  modport sink (
    input  valid, num_accesses, first_time, last_time, read_fraction,
           read_latency, write_latency,
    output ready
  );
endinterface

interface blp_out_if import blp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PEN_W-1:0] penalty;

  modport source (output valid, penalty, input ready);
  modport sink (input valid, penalty, output ready);
endinterface

interface blp_cfg_if import blp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/blp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blp_div
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag for quotients that do not fit and trailing delay stages for alignment.
// ----------------------------------------------------------------------------
module blp_div import blp_pkg::*; #(
  parameter int unsigned NW  = 48,
  parameter int unsigned DW  = 17,
  parameter int unsigned QW  = 42,
  parameter int unsigned LAT = 43,
  parameter int unsigned SW  = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic          sat,
  output logic [SW-1:0] side_out
);

  localparam int unsigned HW = NW - QW;
  localparam int unsigned CW = (HW > DW) ? HW : DW;

  logic          v_r   [LAT];
  logic [DW-1:0] rem_r [LAT];
  logic [QW-1:0] lo_r  [LAT];
  logic [QW-1:0] q_r   [LAT];
  logic [DW-1:0] den_r [LAT];
  logic          sat_r [LAT];
  logic [SW-1:0] sd_r  [LAT];

  logic [CW-1:0] hi_ext;
  logic [CW-1:0] den_ext;
  logic          sat_nxt;

  // The quotient overflows exactly when the upper numerator bits reach the
  // divisor; otherwise they form the starting remainder.
  assign hi_ext  = CW'(num[NW-1:QW]);
  assign den_ext = CW'(den);
  assign sat_nxt = (hi_ext >= den_ext);

  for (genvar i = 0; i < LAT; i++) begin : g_st
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= (i == 0) ? in_valid : v_r[(i == 0) ? 0 : i - 1];
      end
    end

    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[0] <= sat_nxt ? '0 : hi_ext[DW-1:0];
          lo_r[0]  <= num[QW-1:0];
          q_r[0]   <= '0;
          den_r[0] <= den;
          sat_r[0] <= sat_nxt;
          sd_r[0]  <= side_in;
        end
      end
    end else if (i <= QW) begin : g_step
      logic [DW:0] trial;
      logic [DW:0] diff;
      logic        ge;

      assign trial = {rem_r[i-1], lo_r[i-1][QW-1]};
      assign diff  = trial - {1'b0, den_r[i-1]};
      assign ge    = (trial >= {1'b0, den_r[i-1]});

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
          lo_r[i]  <= lo_r[i-1] << 1;
          q_r[i]   <= (q_r[i-1] << 1) | QW'(ge);
          den_r[i] <= den_r[i-1];
          sat_r[i] <= sat_r[i-1];
          sd_r[i]  <= sd_r[i-1];
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= rem_r[i-1];
          lo_r[i]  <= lo_r[i-1];
          q_r[i]   <= q_r[i-1];
          den_r[i] <= den_r[i-1];
          sat_r[i] <= sat_r[i-1];
          sd_r[i]  <= sd_r[i-1];
        end
      end
    end
  end

  assign out_valid = v_r[LAT-1];
  assign quo       = q_r[LAT-1];
  assign sat       = sat_r[LAT-1];
  assign side_out  = sd_r[LAT-1];

endmodule

// ===== rtl/core/bandwidth_latency_penalty.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bandwidth_latency_penalty
// Turns one window of memory accesses into an added-latency penalty.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus carries one item per access window: access count, first and last
//   timestamps, read fraction and read/write latencies. out_bus returns one
//   penalty item (Q24.8 ns) per window, in order. cfg_bus writes the six
//   tuning registers by index; it is always ready and should only be used
//   while no window is in flight.
//   The block takes one item per cycle while out_bus is not stalled. The
//   pipeline is 10 register stages plus the utilization divider (25 stages)
//   plus the term dividers (the longest of 41, 43 and the term-one quotient
//   width plus one). The restoring dividers compute one quotient bit per
//   stage.
//   The whole pipeline advances together whenever the output register is
//   empty or being taken, so a stalled receiver freezes every stage in place
//   and in_bus.ready drops in the same cycle; nothing is dropped or repeated.
//   Reset (synchronous, active low) clears all valid bits and loads the
//   register defaults; payload registers are not cleared.
// ----------------------------------------------------------------------------
module bandwidth_latency_penalty import blp_pkg::*; #(
  parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  blp_in_if.sink           in_bus,
  blp_out_if.source        out_bus,
  blp_cfg_if.sink          cfg_bus
);

  // Widths that follow from the line size.
  localparam int unsigned LBW   = $clog2(LINE_BYTES + 1);
  localparam logic [LBW-1:0] LB_C = LBW'(LINE_BYTES);
  localparam int unsigned BYW   = COUNT_W + LBW;          // bytes in window
  localparam int unsigned UNW   = BYW + UTIL_W;           // bytes << 24
  localparam int unsigned DENW  = TIME_W + PEAK_W;        // window * peak
  localparam int unsigned M1W   = UTIL_W + LEVEL_W;       // U * slope
  localparam int unsigned X1W   = M1W + LBW;              // U * slope * line
  localparam int unsigned T1W   = X1W - 16;               // term one quotient
  localparam int unsigned DDW   = 2 * LEVEL_W;            // d squared
  localparam int unsigned CDDW  = LEVEL_W + DDW;          // C * d^2
  localparam int unsigned CLW   = CDDW + LBW;             // C * d^2 * line
  localparam int unsigned N2W   = CLW + 16;
  localparam int unsigned PQW   = PEAK_W + LEVEL_W;       // peak * q
  localparam int unsigned D2W   = PQW + DDW;              // peak * q * span^2
  localparam int unsigned T3NW  = 2 * LAT_W;              // B * (U - S)
  localparam int unsigned SUM_W = 44;
  localparam int unsigned LAT_A = (T1W + 1 > TERM2_W + 1) ? T1W + 1 : TERM2_W + 1;
  localparam int unsigned LAT_T = (LAT_A > TERM3_W + 1) ? LAT_A : TERM3_W + 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [PEAK_W-1:0]  peak_r;
  logic [LEVEL_W-1:0] knee_r;
  logic [LEVEL_W-1:0] sat_lvl_r;
  logic [LEVEL_W-1:0] slope_r;
  logic [PEN_W-1:0]   max_pen_r;
  logic [31:0]        min_win_r;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r    <= PEAK_RST;
      knee_r    <= KNEE_RST;
      sat_lvl_r <= SAT_RST;
      slope_r   <= SLOPE_RST;
      max_pen_r <= MAX_PEN_RST;
      min_win_r <= MIN_WIN_RST;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        CFG_PEAK:    peak_r    <= cfg_bus.data[PEAK_W-1:0];
        CFG_KNEE:    knee_r    <= cfg_bus.data[LEVEL_W-1:0];
        CFG_SAT:     sat_lvl_r <= cfg_bus.data[LEVEL_W-1:0];
        CFG_SLOPE:   slope_r   <= cfg_bus.data[LEVEL_W-1:0];
        CFG_MAX_PEN: max_pen_r <= cfg_bus.data;
        CFG_MIN_WIN: min_win_r <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  // Values derived from the registers alone. A zero peak or window floor
  // acts as one, and the span and saturation headroom have a 0.001 floor.
  logic [PEAK_W-1:0]  peak_eff;
  logic [31:0]        min_win_eff;
  logic [LEVEL_W-1:0] span;
  logic [LEVEL_W-1:0] q3;
  logic [DDW-1:0]     span_sq_r;

  assign peak_eff    = (peak_r == '0) ? PEAK_W'(1) : peak_r;
  assign min_win_eff = (min_win_r == '0) ? 32'd1 : min_win_r;
  assign span = ((sat_lvl_r > knee_r) && ((sat_lvl_r - knee_r) > EPS_Q16)) ?
                (sat_lvl_r - knee_r) : EPS_Q16;
  assign q3   = (sat_lvl_r < (Q16_ONE - EPS_Q16)) ? (Q16_ONE - sat_lvl_r) : EPS_Q16;

  // The span square only changes with configuration, which users must write only
  // while idle (not enforced here), so one register stage is plenty of settling time.
  always_ff @(posedge clk) begin
    span_sq_r <= DDW'(span) * DDW'(span);
  end

  // --------------------------------------------------------------------------
  // Global pipeline enable: every stage moves when the output can take a word.
  // --------------------------------------------------------------------------
  logic out_valid_r;
  logic en;

  assign en           = !out_valid_r || out_bus.ready;
  assign in_bus.ready = en;

  // Stage 1: observed window and clamped read fraction.
  logic              s1_valid_r;
  logic [COUNT_W-1:0] s1_count_r;
  logic [TIME_W-1:0] s1_win_r;
  logic [FRAC_W-1:0] s1_rf_r;
  logic [LAT_W-1:0]  s1_rl_r;
  logic [LAT_W-1:0]  s1_wl_r;
  logic [TIME_W-1:0] s1_win_nxt;
  logic [FRAC_W-1:0] s1_rf_nxt;

  assign s1_win_nxt = (in_bus.last_time > in_bus.first_time) ?
                      (in_bus.last_time - in_bus.first_time) : '0;
  assign s1_rf_nxt  = (in_bus.read_fraction > Q16_ONE) ? Q16_ONE : in_bus.read_fraction;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_count_r <= in_bus.num_accesses;
      s1_win_r   <= s1_win_nxt;
      s1_rf_r    <= s1_rf_nxt;
      s1_rl_r    <= in_bus.read_latency;
      s1_wl_r    <= in_bus.write_latency;
    end
  end

  // Stage 2: window floor, byte count and the two base latency products.
  logic              s2_valid_r;
  logic [BYW-1:0]    s2_bytes_r;
  logic [TIME_W-1:0] s2_win_r;
  logic [40:0]       s2_pr_r;
  logic [40:0]       s2_pw_r;
  logic [TIME_W-1:0] min_win_ext;

  assign min_win_ext = TIME_W'(min_win_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_bytes_r <= BYW'(s1_count_r) * BYW'(LB_C);
      s2_win_r   <= (s1_win_r < min_win_ext) ? min_win_ext : s1_win_r;
      s2_pr_r    <= 41'(s1_rl_r) * 41'(s1_rf_r);
      s2_pw_r    <= 41'(s1_wl_r) * 41'(Q16_ONE - s1_rf_r);
    end
  end

  // Stage 3: window times peak as two 32x16 partial products; base latency.
  logic             s3_valid_r;
  logic [BYW-1:0]   s3_bytes_r;
  logic [47:0]      s3_dlo_r;
  logic [47:0]      s3_dhi_r;
  logic [LAT_W-1:0] s3_b_r;
  logic [40:0]      s3_bsum;

  assign s3_bsum = s2_pr_r + s2_pw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_bytes_r <= s2_bytes_r;
      s3_dlo_r   <= 48'(s2_win_r[31:0]) * 48'(peak_eff);
      s3_dhi_r   <= 48'(s2_win_r[63:32]) * 48'(peak_eff);
      s3_b_r     <= s3_bsum[39:16];
    end
  end

  // Stage 4: combine the partial products into the utilization divisor.
  logic             s4_valid_r;
  logic [BYW-1:0]   s4_bytes_r;
  logic [DENW-1:0]  s4_den_r;
  logic [LAT_W-1:0] s4_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_bytes_r <= s3_bytes_r;
      s4_den_r   <= (DENW'(s3_dhi_r) << 32) + DENW'(s3_dlo_r);
      s4_b_r     <= s3_b_r;
    end
  end

  // Utilization U = bytes * 2^24 / (window * peak), saturating at 24 bits.
  logic              u_valid;
  logic [UTIL_W-1:0] u_quo;
  logic              u_sat;
  logic [LAT_W-1:0]  u_b;

  blp_div #(
    .NW  (UNW),
    .DW  (DENW),
    .QW  (UTIL_W),
    .LAT (UTIL_W + 1),
    .SW  (LAT_W)
  ) u_div_util (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s4_valid_r),
    .num       ({s4_bytes_r, UTIL_W'(0)}),
    .den       (s4_den_r),
    .side_in   (s4_b_r),
    .out_valid (u_valid),
    .quo       (u_quo),
    .sat       (u_sat),
    .side_out  (u_b)
  );

  // Stage E1: compare against knee and saturation, clip, first product.
  logic               e1_valid_r;
  logic [M1W-1:0]     e1_m1_r;
  logic [LEVEL_W-1:0] e1_c_r;
  logic [LEVEL_W-1:0] e1_d_r;
  logic [LEVEL_W-1:0] e1_q2_r;
  logic [UTIL_W-1:0]  e1_um_r;
  logic               e1_gtk_r;
  logic               e1_gts_r;
  logic [LAT_W-1:0]   e1_b_r;
  logic [UTIL_W-1:0]  util;
  logic [LEVEL_W-1:0] clip;

  assign util = u_sat ? UTIL_MAX : u_quo;
  assign clip = (util > UTIL_W'(sat_lvl_r)) ? sat_lvl_r : util[LEVEL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_valid_r <= 1'b0;
    end else if (en) begin
      e1_valid_r <= u_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_m1_r  <= M1W'(util) * M1W'(slope_r);
      e1_c_r   <= clip;
      e1_d_r   <= (clip >= knee_r) ? (clip - knee_r) : (knee_r - clip);
      e1_q2_r  <= (clip < (Q16_ONE - EPS_Q16)) ? (Q16_ONE - clip) : EPS_Q16;
      e1_um_r  <= util - UTIL_W'(sat_lvl_r);
      e1_gtk_r <= (util > UTIL_W'(knee_r));
      e1_gts_r <= (util > UTIL_W'(sat_lvl_r));
      e1_b_r   <= u_b;
    end
  end

  // Stage E2: line scaling of term one, d squared, peak * q, term three
  // numerator.
  logic               e2_valid_r;
  logic [T1W-1:0]     e2_x1_r;
  logic [DDW-1:0]     e2_dd_r;
  logic [LEVEL_W-1:0] e2_c_r;
  logic [PQW-1:0]     e2_pq_r;
  logic [T3NW-1:0]    e2_t3n_r;
  logic               e2_gtk_r;
  logic               e2_gts_r;
  logic [LAT_W-1:0]   e2_b_r;
  logic [X1W-1:0]     e2_x1_nxt;

  assign e2_x1_nxt = X1W'(e1_m1_r) * X1W'(LB_C);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e2_valid_r <= 1'b0;
    end else if (en) begin
      e2_valid_r <= e1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2_x1_r  <= e2_x1_nxt[X1W-1:16];
      e2_dd_r  <= DDW'(e1_d_r) * DDW'(e1_d_r);
      e2_c_r   <= e1_c_r;
      e2_pq_r  <= PQW'(peak_eff) * PQW'(e1_q2_r);
      e2_t3n_r <= T3NW'(e1_b_r) * T3NW'(e1_um_r);
      e2_gtk_r <= e1_gtk_r;
      e2_gts_r <= e1_gts_r;
      e2_b_r   <= e1_b_r;
    end
  end

  // Stage E3: C * d^2 and the queueing divisor.
  logic             e3_valid_r;
  logic [T1W-1:0]   e3_x1_r;
  logic [CDDW-1:0]  e3_cdd_r;
  logic [D2W-1:0]   e3_den2_r;
  logic [T3NW-1:0]  e3_t3n_r;
  logic             e3_gtk_r;
  logic             e3_gts_r;
  logic [LAT_W-1:0] e3_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e3_valid_r <= 1'b0;
    end else if (en) begin
      e3_valid_r <= e2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e3_x1_r   <= e2_x1_r;
      e3_cdd_r  <= CDDW'(e2_c_r) * CDDW'(e2_dd_r);
      e3_den2_r <= D2W'(e2_pq_r) * D2W'(span_sq_r);
      e3_t3n_r  <= e2_t3n_r;
      e3_gtk_r  <= e2_gtk_r;
      e3_gts_r  <= e2_gts_r;
      e3_b_r    <= e2_b_r;
    end
  end

  // Stage E4: line scaling of the queueing numerator.
  logic             e4_valid_r;
  logic [T1W-1:0]   e4_x1_r;
  logic [CLW-1:0]   e4_cl_r;
  logic [D2W-1:0]   e4_den2_r;
  logic [T3NW-1:0]  e4_t3n_r;
  logic             e4_gtk_r;
  logic             e4_gts_r;
  logic [LAT_W-1:0] e4_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e4_valid_r <= 1'b0;
    end else if (en) begin
      e4_valid_r <= e3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e4_x1_r   <= e3_x1_r;
      e4_cl_r   <= CLW'(e3_cdd_r) * CLW'(LB_C);
      e4_den2_r <= e3_den2_r;
      e4_t3n_r  <= e3_t3n_r;
      e4_gtk_r  <= e3_gtk_r;
      e4_gts_r  <= e3_gts_r;
      e4_b_r    <= e3_b_r;
    end
  end

  // Three term dividers run side by side with the same latency, so their
  // quotients come out in the same cycle. Each one carries part of the
  // item's remaining context.
  logic             d1_valid;
  logic [T1W-1:0]   d1_quo;
  logic             d1_sat;
  logic             d1_gtk;
  logic             d2_valid;
  logic [TERM2_W-1:0] d2_quo;
  logic             d2_sat;
  logic             d2_gts;
  logic             d3_valid;
  logic [TERM3_W-1:0] d3_quo;
  logic             d3_sat;
  logic [LAT_W-1:0] d3_b;

  // Term one: (line * U * slope / 2^16) / peak.
  blp_div #(
    .NW  (T1W + 1),
    .DW  (PEAK_W),
    .QW  (T1W),
    .LAT (LAT_T),
    .SW  (1)
  ) u_div_low (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (e4_valid_r),
    .num       ({1'b0, e4_x1_r}),
    .den       (peak_eff),
    .side_in   (e4_gtk_r),
    .out_valid (d1_valid),
    .quo       (d1_quo),
    .sat       (d1_sat),
    .side_out  (d1_gtk)
  );

  // Term two: line * 2^16 * C * d^2 / (peak * q * span^2), 40-bit saturating.
  blp_div #(
    .NW  (N2W),
    .DW  (D2W),
    .QW  (TERM2_W),
    .LAT (LAT_T),
    .SW  (1)
  ) u_div_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (e4_valid_r),
    .num       ({e4_cl_r, 16'd0}),
    .den       (e4_den2_r),
    .side_in   (e4_gts_r),
    .out_valid (d2_valid),
    .quo       (d2_quo),
    .sat       (d2_sat),
    .side_out  (d2_gts)
  );

  // Term three: B * (U - S) / max(0.001, 1 - S).
  blp_div #(
    .NW  (T3NW),
    .DW  (LEVEL_W),
    .QW  (TERM3_W),
    .LAT (LAT_T),
    .SW  (LAT_W)
  ) u_div_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (e4_valid_r),
    .num       (e4_t3n_r),
    .den       (q3),
    .side_in   (e4_b_r),
    .out_valid (d3_valid),
    .quo       (d3_quo),
    .sat       (d3_sat),
    .side_out  (d3_b)
  );

  // Stage F1: sum of the terms and the cap.
  logic               f1_valid_r;
  logic [SUM_W-1:0]   f1_sum_r;
  logic [PEN_W-1:0]   f1_cap_r;
  logic [T1W-1:0]     t1;
  logic [TERM2_W-1:0] t2;
  logic [TERM3_W-1:0] t3;
  logic [PEN_W-1:0]   b10;

  assign t1  = d1_sat ? {T1W{1'b1}} : d1_quo;
  assign t2  = d2_sat ? TERM2_MAX : d2_quo;
  assign t3  = d3_sat ? TERM3_MAX : d3_quo;
  assign b10 = PEN_W'(d3_b) * PEN_W'(10);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (en) begin
      f1_valid_r <= d3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_sum_r <= SUM_W'(t1) + (d1_gtk ? SUM_W'(t2) : '0) + (d2_gts ? SUM_W'(t3) : '0);
      f1_cap_r <= (b10 < max_pen_r) ? max_pen_r : b10;
    end
  end

  // Output register: clamp to the cap.
  logic [PEN_W-1:0] out_penalty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_penalty_r <= (f1_sum_r > SUM_W'(f1_cap_r)) ? f1_cap_r : f1_sum_r[PEN_W-1:0];
    end
  end

  assign out_bus.valid   = out_valid_r;
  assign out_bus.penalty = out_penalty_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The three term dividers must stay in lockstep.
  a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
    (d1_valid == d3_valid) && (d2_valid == d3_valid))
    else $error("term dividers out of alignment");

  // The saturation term quotient always fits its width.
  a_t3_fits: assert property (@(posedge clk) disable iff (!rst_n)
    d3_valid |-> !d3_sat)
    else $error("saturation term overflowed");

  // A loaded penalty never exceeds the cap it was clamped against.
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (en && f1_valid_r) |=> (out_penalty_r <= $past(f1_cap_r)))
    else $error("penalty above cap");

  // Nothing leaves the block in the cycle after reset.
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid_r)
    else $error("output valid right after reset");

endmodule
